[rtl/swd_pkg.sv]
// Shared constants, item types and the CRC-8 byte update for the sensor word deframer.
`default_nettype none

package swd_pkg;

  localparam logic [1:0] MAX_WORDS = 2'd3;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scaling applied to a word, chosen by its position in the frame when measurement mode is on.
  localparam logic [1:0] KIND_RAW  = 2'd0;
  localparam logic [1:0] KIND_TEMP = 2'd1;
  localparam logic [1:0] KIND_HUM  = 2'd2;

  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [14:0] HUM_SPAN  = 15'd10000;
  localparam logic signed [16:0] TEMP_OFFSET = -17'sd4500;

  localparam logic [31:0] FULL_SCALE = 32'd65535;

  localparam logic [2:0] ADDR_WORD_COUNT = 3'd0;
  localparam logic [2:0] ADDR_MEAS_MODE  = 3'd4;

  typedef struct packed {
    logic [15:0] raw_word;
    logic [1:0]  word_index;
    logic        crc_ok;
    logic        frame_ok;
    logic        last_word;
    logic [1:0]  kind;
  } word_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/swd_deframe.sv]
// Byte framing, CRC-8 check and frame bookkeeping, with a registered word item.
`default_nettype none

module swd_deframe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          frame_start,
  input  wire logic [1:0]    word_count,
  input  wire logic          measurement_mode,
  output logic               out_valid,
  input  wire logic          out_ready,
  output swd_pkg::word_t     word
);

  logic [1:0] byte_phase, byte_phase_next;
  logic [1:0] word_counter, word_counter_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] held_high_byte, held_high_byte_next;
  logic [7:0] held_low_byte, held_low_byte_next;
  logic       frame_error, frame_error_next;

  logic           accept;
  logic           emit;
  logic [1:0]     phase_eff;
  logic [1:0]     counter_eff;
  logic           error_eff;
  logic [1:0]     count_eff;
  logic [7:0]     crc_calc;
  logic           crc_match;
  logic           is_last;
  logic           error_upd;
  swd_pkg::word_t word_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // A start mark restarts the frame before the byte is taken as a high byte.
  assign phase_eff   = frame_start ? 2'd0 : byte_phase;
  assign counter_eff = frame_start ? 2'd0 : word_counter;
  assign error_eff   = frame_start ? 1'b0 : frame_error;

  always_comb begin
    if (word_count == 2'd0) begin
      count_eff = 2'd1;
    end else if (word_count > swd_pkg::MAX_WORDS) begin
      count_eff = swd_pkg::MAX_WORDS;
    end else begin
      count_eff = word_count;
    end
  end

  assign crc_calc  = swd_pkg::crc8_byte(
                       (phase_eff == 2'd1) ? running_crc : swd_pkg::CRC_INIT, rx_byte);
  assign crc_match = (running_crc == rx_byte);
  assign is_last   = (({1'b0, counter_eff} + 3'd1) >= {1'b0, count_eff});
  assign error_upd = error_eff || !crc_match;
  assign emit      = (phase_eff == 2'd2);

  always_comb begin
    byte_phase_next     = byte_phase;
    word_counter_next   = counter_eff;
    running_crc_next    = running_crc;
    held_high_byte_next = held_high_byte;
    held_low_byte_next  = held_low_byte;
    frame_error_next    = error_eff;
    case (phase_eff)
      2'd1: begin
        held_low_byte_next = rx_byte;
        running_crc_next   = crc_calc;
        byte_phase_next    = 2'd2;
      end
      2'd2: begin
        byte_phase_next  = 2'd0;
        running_crc_next = swd_pkg::CRC_INIT;
        if (is_last) begin
          word_counter_next = 2'd0;
          frame_error_next  = 1'b0;
        end else begin
          word_counter_next = counter_eff + 2'd1;
          frame_error_next  = error_upd;
        end
      end
      default: begin
        // The unused phase code behaves as the high-byte phase.
        held_high_byte_next = rx_byte;
        running_crc_next    = crc_calc;
        byte_phase_next     = 2'd1;
      end
    endcase
  end

  always_comb begin
    word_next.raw_word   = {held_high_byte, held_low_byte};
    word_next.word_index = counter_eff;
    word_next.crc_ok     = crc_match;
    word_next.frame_ok   = is_last && !error_upd;
    word_next.last_word  = is_last;
    if (measurement_mode && counter_eff == 2'd1) begin
      word_next.kind = swd_pkg::KIND_TEMP;
    end else if (measurement_mode && counter_eff == 2'd2) begin
      word_next.kind = swd_pkg::KIND_HUM;
    end else begin
      word_next.kind = swd_pkg::KIND_RAW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      byte_phase     <= 2'd0;
      word_counter   <= 2'd0;
      running_crc    <= swd_pkg::CRC_INIT;
      held_high_byte <= 8'd0;
      held_low_byte  <= 8'd0;
      frame_error    <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= accept && emit;
      end
      if (accept) begin
        byte_phase     <= byte_phase_next;
        word_counter   <= word_counter_next;
        running_crc    <= running_crc_next;
        held_high_byte <= held_high_byte_next;
        held_low_byte  <= held_low_byte_next;
        frame_error    <= frame_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

[rtl/swd_scale.sv]
// Measurement scaling of a word: constant multiply, then division by full scale; raw words pass through.
`default_nettype none

module swd_scale (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire swd_pkg::word_t word_in,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [15:0]         raw_word,
  output logic [1:0]          word_index,
  output logic                crc_ok,
  output logic                frame_ok,
  output logic signed [16:0]  scaled_value,
  output logic                last_word
);

  logic           prod_valid;
  swd_pkg::word_t prod_word;
  logic [30:0]    prod;
  logic [30:0]    prod_next;
  logic           out_ready_int;

  logic [31:0]        quot_sum;
  logic [15:0]        quot_est;
  logic [31:0]        rem;
  logic [15:0]        quot;
  logic signed [16:0] scaled_next;

  assign out_ready_int = !out_valid || out_ready;
  assign in_ready      = !prod_valid || out_ready_int;

  assign prod_next = {15'd0, word_in.raw_word} *
                     {16'd0, (word_in.kind == swd_pkg::KIND_TEMP) ? swd_pkg::TEMP_SPAN
                                                               : swd_pkg::HUM_SPAN};

  // x / 65535 is estimated as (x + x/65536) / 65536, which never overshoots and
  // falls short by at most one; the remainder check puts it right.
  assign quot_sum = {1'b0, prod} + {17'd0, prod[30:16]};
  assign quot_est = quot_sum[31:16];
  assign rem      = {1'b0, prod} - {quot_est, 16'd0} + {16'd0, quot_est};
  assign quot     = quot_est + {15'd0, (rem >= swd_pkg::FULL_SCALE)};

  always_comb begin
    case (prod_word.kind)
      swd_pkg::KIND_TEMP: scaled_next = swd_pkg::TEMP_OFFSET + $signed({1'b0, quot});
      swd_pkg::KIND_HUM:  scaled_next = $signed({1'b0, quot});
      default:            scaled_next = $signed({1'b0, prod_word.raw_word});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        prod_valid <= in_valid;
      end
      if (out_ready_int) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_word <= word_in;
      prod      <= prod_next;
    end
    if (prod_valid && out_ready_int) begin
      raw_word     <= prod_word.raw_word;
      word_index   <= prod_word.word_index;
      crc_ok       <= prod_word.crc_ok;
      frame_ok     <= prod_word.frame_ok;
      last_word    <= prod_word.last_word;
      scaled_value <= scaled_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sensor_word_deframer_crc8.sv]
// Sensor response deframer top level: register port, byte deframer and word scaling.
// Throughput: one byte item per cycle while the output is not stalled, with no stall between frames.
// A word item is formed once its CRC byte is accepted and passes in turn through
// the deframe register, the multiplier register and the output register to the
// output. High and low bytes produce no item.
// Reset (synchronous, rst high) empties the pipeline, clears the frame state and
// sets word_count to 3 and measurement_mode to 1.
`default_nettype none

module sensor_word_deframer_crc8 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [15:0] raw_word, [17:16] word_index, [18] crc_ok,
                                      // [19] frame_ok, [36:20] scaled_value, [39:37] zero
  output logic             m_tlast    // last_word
);

  logic [1:0] word_count;
  logic       measurement_mode;
  logic       cfg_write;

  logic           word_valid;
  logic           word_ready;
  swd_pkg::word_t word;

  logic [15:0]        raw_word;
  logic [1:0]         word_index;
  logic               crc_ok;
  logic               frame_ok;
  logic signed [16:0] scaled_value;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Only address bit 2 selects a register; the byte offset bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count       <= 2'd3;
      measurement_mode <= 1'b1;
    end else if (cfg_write) begin
      if (paddr[2] == swd_pkg::ADDR_MEAS_MODE[2]) begin
        measurement_mode <= pwdata[0];
      end else begin
        word_count <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      swd_pkg::ADDR_MEAS_MODE[2]:  prdata = {31'd0, measurement_mode};
      swd_pkg::ADDR_WORD_COUNT[2]: prdata = {30'd0, word_count};
      default:                     prdata = 32'd0;
    endcase
  end

  swd_deframe u_deframe (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .rx_byte          (s_tdata),
    .frame_start      (s_tuser),
    .word_count       (word_count),
    .measurement_mode (measurement_mode),
    .out_valid        (word_valid),
    .out_ready        (word_ready),
    .word             (word)
  );

  swd_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (word_valid),
    .in_ready     (word_ready),
    .word_in      (word),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .raw_word     (raw_word),
    .word_index   (word_index),
    .crc_ok       (crc_ok),
    .frame_ok     (frame_ok),
    .scaled_value (scaled_value),
    .last_word    (m_tlast)
  );

  assign m_tdata = {3'd0, scaled_value, frame_ok, crc_ok, word_index, raw_word};

endmodule

`default_nettype wire

[test/sensor_word_deframer_crc8_test.sv]
// Self-checking testbench for the sensor word deframer with CRC-8 check and scaling.
module sensor_word_deframer_crc8_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CRC_SEED = 8'hFF;
  localparam logic [7:0] CRC_GEN  = 8'h31;
  localparam logic [1:0] IDX_TEMP = 2'd1;
  localparam logic [1:0] IDX_HUM  = 2'd2;
  localparam logic signed [16:0] TEMP_BASE = -17'sd4500;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [15:0]        raw;
    logic [1:0]         idx;
    logic               crc_ok;
    logic               frame_ok;
    logic signed [16:0] scaled;
    logic               last;
  } deframed_word_t;

  typedef struct {
    logic [7:0]     rx;
    logic           start;
    logic           fix_crc;  // send the correct CRC xor rx instead of rx
    bit             typed;
    deframed_word_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [15:0] raw_word, [17:16] word_index, [18] crc_ok,
                               // [19] frame_ok, [36:20] scaled_value, [39:37] zero
  logic        m_tlast;        // last_word

  // Predicted block state and registers.
  logic [1:0] cfg_words = 2'd3;
  logic       cfg_meas = 1'b1;
  logic [1:0] dphase = '0;
  logic [1:0] dword = '0;
  logic [7:0] dcrc = CRC_SEED;
  logic [7:0] dhi = '0;
  logic [7:0] dlo = '0;
  logic       dferr = 1'b0;

  deframed_word_t pending_words[$];
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  bit  random_running = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{16'h0000, 2'd0, 1'b1, 1'b0, 17'sd0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 2'd1, 1'b1, 1'b0, 17'sd13000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 2'd2, 1'b1, 1'b1, 17'sd10000, 1'b1}},
    // A new frame with no start mark; its first word has a bad CRC.
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{16'h0000, 2'd0, 1'b0, 1'b0, 17'sd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{16'h0000, 2'd1, 1'b1, 1'b0, -17'sd4500, 1'b0}},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},
    '{8'hBE, 1'b1, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b0, 1'b1, '{16'hBEEF, 2'd0, 1'b1, 1'b0, 17'sd48879, 1'b0}},
    // A start mark in the middle of a word restarts the frame on that byte.
    '{8'h12, 1'b0, 1'b0, 1'b0, '0},
    '{8'h34, 1'b1, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0}
  };

  sensor_word_deframer_crc8 uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_GEN) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Advances the predicted state by one byte; returns 1 when a word is emitted.
  function automatic bit deframe_byte(input logic [7:0] b, input logic start,
                                      output deframed_word_t w);
    logic [15:0] word;
    logic [1:0]  n;
    logic [31:0] prod;
    logic        last;
    w = '0;
    if (start) begin
      dphase = 2'd0;
      dword = 2'd0;
      dcrc = CRC_SEED;
      dferr = 1'b0;
    end
    if (dphase == 2'd0 || dphase == 2'd3) begin
      dhi = b;
      dcrc = crc8_update(CRC_SEED, b);
      dphase = 2'd1;
      return 1'b0;
    end
    if (dphase == 2'd1) begin
      dlo = b;
      dcrc = crc8_update(dcrc, b);
      dphase = 2'd2;
      return 1'b0;
    end
    word = {dhi, dlo};
    n = (cfg_words == 2'd0) ? 2'd1 : cfg_words;
    last = ({1'b0, dword} + 3'd1) >= {1'b0, n};
    w.raw = word;
    w.idx = dword;
    w.crc_ok = (dcrc == b);
    if (!w.crc_ok) dferr = 1'b1;
    w.frame_ok = last && !dferr;
    w.last = last;
    if (cfg_meas && dword == IDX_TEMP) begin
      prod = 32'd17500 * word;
      w.scaled = 17'(prod / 32'd65535) + TEMP_BASE;
    end else if (cfg_meas && dword == IDX_HUM) begin
      prod = 32'd10000 * word;
      w.scaled = 17'(prod / 32'd65535);
    end else begin
      w.scaled = {1'b0, word};
    end
    dphase = 2'd0;
    dcrc = CRC_SEED;
    if (last) begin
      dword = 2'd0;
      dferr = 1'b0;
    end else begin
      dword = dword + 2'd1;
    end
    return 1'b1;
  endfunction

  // Offers one item after a random gap and records the word it is predicted to produce.
  task automatic push_byte(input logic [7:0] b, input logic start,
                           input bit typed, input deframed_word_t given);
    int gap;
    deframed_word_t w;
    gap = (quiet || hold_off) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(b, start, w)) pending_words.push_back(typed ? given : w);
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic lead, input bit corrupt);
    logic [7:0] hi, lo, chk;
    hi = data_byte();
    lo = data_byte();
    chk = crc8_update(crc8_update(CRC_SEED, hi), lo);
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    push_byte(hi, lead, 1'b0, '0);
    push_byte(lo, 1'b0, 1'b0, '0);
    push_byte(chk, 1'b0, 1'b0, '0);
  endtask

  // Lets the pipeline run dry so that a register write lands while the block is idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == swd_pkg::ADDR_WORD_COUNT) cfg_words = data[1:0];
    else if (addr == swd_pkg::ADDR_MEAS_MODE) cfg_meas = data[0];
  endtask

  always @(posedge clk) begin : sink
    deframed_word_t want;
    int next_stall;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $error("word item with none expected: tdata %h tlast %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[15:0] !== want.raw) begin
          $error("raw_word: expected %h, got %h", want.raw, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[17:16] !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, m_tdata[17:16]);
          mismatches++;
        end
        if (m_tdata[18] !== want.crc_ok) begin
          $error("crc_ok: expected %b, got %b", want.crc_ok, m_tdata[18]);
          mismatches++;
        end
        if (m_tdata[19] !== want.frame_ok) begin
          $error("frame_ok: expected %b, got %b", want.frame_ok, m_tdata[19]);
          mismatches++;
        end
        if (m_tdata[36:20] !== want.scaled) begin
          $error("scaled_value: expected %0d, got %0d", want.scaled, $signed(m_tdata[36:20]));
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, m_tlast);
          mismatches++;
        end
      end
      next_stall = quiet ? 0 : $urandom_range(0, 8);
    end else begin
      next_stall = (stall_left > 0) ? stall_left - 1 : 0;
    end
    stall_left <= next_stall;
    m_tready <= (next_stall == 0) && !hold_off;
  end

  // One long back-pressure stretch while the sender keeps offering items.
  initial begin
    wait (random_running);
    repeat ($urandom_range(100, 400)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] phase_words [8];
    logic       phase_meas [8];
    logic [7:0] b;
    int target, n;
    phase_words = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0};
    phase_meas  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run with the register values left by reset.
    foreach (directed_rows[i]) begin
      b = directed_rows[i].fix_crc ? (dcrc ^ directed_rows[i].rx) : directed_rows[i].rx;
      push_byte(b, directed_rows[i].start, directed_rows[i].typed, directed_rows[i].want);
    end

    // Lowering word_count in mid-frame: the word counter then stands past the end.
    send_word(1'b0, 1'b0);
    settle();
    cfg_write(swd_pkg::ADDR_WORD_COUNT, 32'd1);
    send_word(1'b0, 1'b0);

    random_running <= 1'b1;
    for (int p = 0; p < 8; p++) begin
      settle();
      quiet <= (p % 3 == 1);
      cfg_write(swd_pkg::ADDR_WORD_COUNT, {30'd0, phase_words[p]});
      cfg_write(swd_pkg::ADDR_MEAS_MODE, {31'd0, phase_meas[p]});
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: loose bytes with stray start marks break the word alignment.
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom), ($urandom_range(0, 3) == 0),
                                                 1'b0, '0);
        end else begin
          n = (cfg_words == 2'd0) ? 1 : cfg_words;
          for (int k = 0; k < n; k++) begin
            send_word((k == 0) && ((dphase != 2'd0) || ($urandom_range(0, 1) == 1)),
                      ($urandom_range(0, 7) == 0));
          end
        end
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
